// File: rtl/core/bcs_pkg.sv
// Shared types, status and opcode codes, and register indexes for the
// block I/O command splitter. No dependencies.
package bcs_pkg;

    localparam int PAGE_BYTES_DEF      = 4096;
    localparam int MAX_COMMANDS_DEF    = 64;
    localparam int MAX_QUEUE_DEPTH_DEF = 64;
    localparam int QUEUE_WORDS         = 2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD        = 3'd1;
    localparam logic [2:0] ST_MISALIGNED = 3'd2;
    localparam logic [2:0] ST_RANGE      = 3'd3;
    localparam logic [2:0] ST_BLOCK      = 3'd4;
    localparam logic [2:0] ST_LONG       = 3'd5;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] CFG_ENABLED  = 3'd0;
    localparam logic [2:0] CFG_SHIFT    = 3'd1;
    localparam logic [2:0] CFG_CAPACITY = 3'd2;
    localparam logic [2:0] CFG_NSID     = 3'd3;
    localparam logic [2:0] CFG_DEPTH    = 3'd4;

    localparam logic [4:0]  SHIFT_RST = 5'd9;
    localparam logic [31:0] NSID_RST  = 32'd1;
    localparam logic [6:0]  DEPTH_RST = 7'd64;
    localparam logic [4:0]  SECTOR_SHIFT = 5'd9;

    typedef struct packed {
        logic        enabled;
        logic [4:0]  shift;
        logic [63:0] capacity;
        logic [31:0] nsid;
        logic [6:0]  depth;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic        wr;
        logic [63:0] lba;
        logic [31:0] left;
        logic [4:0]  mnlog;
    } t_desc;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  opcode;
        logic [15:0] command_id;
        logic [5:0]  queue_slot;
        logic [5:0]  doorbell_tail;
        logic [31:0] command_namespace;
        logic [63:0] start_block;
        logic [2:0]  blocks_minus_one;
        logic        last;
    } t_res;

endpackage

// File: rtl/core/block_io_command_splitter.sv
// Top level of the block I/O command splitter: configuration registers,
// front end, descriptor queue and back end. Depends on bcs_pkg and submodules.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata start,count; tuser is_write
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata command; tuser status,opcode
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// A request is checked in the cycle after it is taken and queued as a descriptor.
// The back end takes a descriptor in its idle state, then issues one command per
// cycle while the output is free and no reduction is pending; an error result is
// loaded into the output register as its descriptor is taken. If the tail lies
// over one depth beyond a reduced queue depth, the first command waits in the reduce
// state while the depth is subtracted. Reset is synchronous and active low; a stalled
// output holds its word while the two-word queue keeps the front end taking requests.
module block_io_command_splitter #(
    parameter int PAGE_BYTES      = bcs_pkg::PAGE_BYTES_DEF,
    parameter int MAX_COMMANDS    = bcs_pkg::MAX_COMMANDS_DEF,
    parameter int MAX_QUEUE_DEPTH = bcs_pkg::MAX_QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,  // start_sector, sector_count
    input  logic          s_axis_tuser,  // is_write
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // command_id, queue_slot, doorbell_tail, command_namespace, start_block,
    // blocks_minus_one, one zero pad bit
    output logic [127:0]  m_axis_tdata,
    output logic [4:0]    m_axis_tuser,  // status, opcode
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    import bcs_pkg::*;

    t_cfg  r_cfg;
    t_desc f_desc, q_desc;
    t_res  b_res;
    logic  f_push, q_full, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled  <= 1'b0;
            r_cfg.shift    <= SHIFT_RST;
            r_cfg.capacity <= 64'd0;
            r_cfg.nsid     <= NSID_RST;
            r_cfg.depth    <= DEPTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLED:  r_cfg.enabled  <= i_cfg_data[0];
                CFG_SHIFT:    r_cfg.shift    <= i_cfg_data[4:0];
                CFG_CAPACITY: r_cfg.capacity <= i_cfg_data;
                CFG_NSID:     r_cfg.nsid     <= i_cfg_data[31:0];
                CFG_DEPTH:    r_cfg.depth    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    bcs_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_start (s_axis_tdata[63:0]),
        .i_count (s_axis_tdata[95:64]),
        .i_wr    (s_axis_tuser),
        .o_push  (f_push),
        .o_desc  (f_desc),
        .i_full  (q_full)
    );

    bcs_fifo #(
        .DEPTH (QUEUE_WORDS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_desc),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_desc),
        .i_pop   (q_pop)
    );

    bcs_back #(
        .MAX_QUEUE_DEPTH (MAX_QUEUE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q       (q_desc),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (b_res)
    );

    assign m_axis_tdata = {1'b0, b_res.blocks_minus_one, b_res.start_block,
                           b_res.command_namespace, b_res.doorbell_tail,
                           b_res.queue_slot, b_res.command_id};
    assign m_axis_tuser = {b_res.opcode, b_res.status};
    assign m_axis_tlast = b_res.last;

endmodule

// File: rtl/core/bcs_front.sv
// Front end: takes request words, checks them and builds a descriptor.
// Depends on bcs_pkg.
module bcs_front #(
    parameter int PAGE_BYTES   = bcs_pkg::PAGE_BYTES_DEF,
    parameter int MAX_COMMANDS = bcs_pkg::MAX_COMMANDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bcs_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [63:0]    i_start,
    input  logic [31:0]    i_count,
    input  logic           i_wr,
    output logic           o_push,
    output bcs_pkg::t_desc o_desc,
    input  logic           i_full
);
    import bcs_pkg::*;

    localparam int PAGE_LOG = $clog2(PAGE_BYTES);

    logic        r_valid;
    logic [63:0] r_start;
    logic [31:0] r_count;
    logic        r_wr;

    logic [4:0]  fshift;
    logic [4:0]  mnlog;
    logic [63:0] fmask;
    logic [64:0] sum;
    logic [31:0] left;
    logic [32:0] ncmd_sum;
    logic [32:0] ncmd;
    logic        e_bad, e_mis, e_rng, e_blk, e_long;

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_start <= i_start;
            r_count <= i_count;
            r_wr    <= i_wr;
        end
    end

    always_comb begin
        fshift   = i_cfg.shift - SECTOR_SHIFT;
        mnlog    = 5'(PAGE_LOG) - i_cfg.shift;
        fmask    = (64'd1 << fshift) - 64'd1;
        sum      = {1'b0, r_start} + {33'd0, r_count};
        left     = r_count >> fshift;
        ncmd_sum = {1'b0, left} + (33'd1 << mnlog) - 33'd1;
        ncmd     = ncmd_sum >> mnlog;
        e_bad    = !i_cfg.enabled || (r_count == 32'd0);
        e_mis    = (i_cfg.shift < SECTOR_SHIFT) || ((r_start & fmask) != 64'd0)
                   || ((r_count & fmask[31:0]) != 32'd0);
        e_rng    = sum > {1'b0, i_cfg.capacity};
        e_blk    = i_cfg.shift > 5'(PAGE_LOG);
        e_long   = ncmd > 33'(MAX_COMMANDS);

        o_desc.wr    = r_wr;
        o_desc.lba   = r_start >> fshift;
        o_desc.left  = left;
        o_desc.mnlog = mnlog;
        if (e_bad) begin
            o_desc.status = ST_BAD;
        end else if (e_mis) begin
            o_desc.status = ST_MISALIGNED;
        end else if (e_rng) begin
            o_desc.status = ST_RANGE;
        end else if (e_blk) begin
            o_desc.status = ST_BLOCK;
        end else if (e_long) begin
            o_desc.status = ST_LONG;
        end else begin
            o_desc.status = ST_OK;
        end
    end

endmodule

// File: rtl/core/bcs_fifo.sv
// Small register queue between front and back end.
// Depends on bcs_pkg for the descriptor type.
module bcs_fifo #(
    parameter int DEPTH = bcs_pkg::QUEUE_WORDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bcs_pkg::t_desc i_data,
    output logic           o_full,
    output logic           o_valid,
    output bcs_pkg::t_desc o_data,
    input  logic           i_pop
);
    import bcs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/core/bcs_back.sv
// Back end: turns descriptors into page-sized commands, owns command id and
// queue tail, and holds the output register. Depends on bcs_pkg.
module bcs_back #(
    parameter int MAX_QUEUE_DEPTH = bcs_pkg::MAX_QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bcs_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  bcs_pkg::t_desc i_q,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output bcs_pkg::t_res  o_res
);
    import bcs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ISSUE  = 2'd1;
    localparam logic [1:0] S_REDUCE = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [15:0] r_cid, n_cid;
    logic [5:0]  r_tail, n_tail;
    logic [6:0]  r_rem, n_rem;
    logic [31:0] r_left, n_left;
    logic [63:0] r_lba, n_lba;
    logic [4:0]  r_mnlog, n_mnlog;
    logic        r_wr, n_wr;
    logic        r_out_valid, n_out_valid;
    t_res        r_out, n_out;

    logic        out_free;
    logic [6:0]  dsat, c1, s1, cmd_tail;
    logic        cmd_go;
    logic [31:0] maxn, nblk, left_rem;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        if (i_cfg.depth < 7'd2) begin
            dsat = 7'd2;
        end else if (i_cfg.depth > 7'(MAX_QUEUE_DEPTH)) begin
            dsat = 7'(MAX_QUEUE_DEPTH);
        end else begin
            dsat = i_cfg.depth;
        end
        c1       = {1'b0, r_tail} + 7'd1;
        s1       = (c1 >= dsat) ? c1 - dsat : c1;
        maxn     = 32'd1 << r_mnlog;
        nblk     = (r_left > maxn) ? maxn : r_left;
        left_rem = r_left - nblk;

        n_state     = r_state;
        n_cid       = r_cid;
        n_tail      = r_tail;
        n_rem       = r_rem;
        n_left      = r_left;
        n_lba       = r_lba;
        n_mnlog     = r_mnlog;
        n_wr        = r_wr;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        cmd_go      = 1'b0;
        cmd_tail    = s1;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_q.status != ST_OK) begin
                        n_out        = '0;
                        n_out.status = i_q.status;
                        n_out.last   = 1'b1;
                        n_out_valid  = 1'b1;
                    end else begin
                        n_left  = i_q.left;
                        n_lba   = i_q.lba;
                        n_mnlog = i_q.mnlog;
                        n_wr    = i_q.wr;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (s1 >= dsat) begin
                    n_rem   = s1;
                    n_state = S_REDUCE;
                end else if (out_free) begin
                    cmd_go = 1'b1;
                end
            end
            S_REDUCE: begin
                cmd_tail = r_rem;
                if (r_rem >= dsat) begin
                    n_rem = r_rem - dsat;
                end else if (out_free) begin
                    cmd_go = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd_go) begin
            n_out.status            = ST_OK;
            n_out.opcode            = r_wr ? OP_WRITE : OP_READ;
            n_out.command_id        = r_cid;
            n_out.queue_slot        = r_tail;
            n_out.doorbell_tail     = cmd_tail[5:0];
            n_out.command_namespace = i_cfg.nsid;
            n_out.start_block       = r_lba;
            n_out.blocks_minus_one  = 3'(nblk - 32'd1);
            n_out.last              = left_rem == 32'd0;
            n_out_valid             = 1'b1;
            n_cid                   = r_cid + 16'd1;
            n_tail                  = cmd_tail[5:0];
            n_left                  = left_rem;
            n_lba                   = r_lba + {32'd0, nblk};
            n_state                 = (left_rem == 32'd0) ? S_IDLE : S_ISSUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cid       <= 16'd1;
            r_tail      <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cid       <= n_cid;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
        r_rem   <= n_rem;
        r_left  <= n_left;
        r_lba   <= n_lba;
        r_mnlog <= n_mnlog;
        r_wr    <= n_wr;
        r_out   <= n_out;
    end

endmodule

// File: rtl/core/bcs_checker.sv
// Port-level checks for the block I/O command splitter, bound to the top.
// Depends on bcs_pkg and block_io_command_splitter.
module bcs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [4:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import bcs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] != ST_OK) |->
            m_axis_tlast && (m_axis_tdata == 128'd0) && (m_axis_tuser[4:3] == OP_NONE))
        else $error("error result not a lone zeroed word");

    a_ok_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == ST_OK) |->
            (m_axis_tuser[4:3] == OP_WRITE) || (m_axis_tuser[4:3] == OP_READ))
        else $error("issued command without opcode");

    a_tail_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == ST_OK) |->
            m_axis_tdata[21:16] != m_axis_tdata[27:22])
        else $error("doorbell tail equals slot used");

endmodule

bind block_io_command_splitter bcs_checker u_bcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
